// ===== hw/rtl/whp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// whp_pkg: shared types and constants of the wave header parser
// Word structs for both channels, parse phase and status codes, chunk tags.
// ----------------------------------------------------------------------------
package whp_pkg;

    // little-endian tags as they sit in the shift register after four bytes
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_MIN  = 32'd16;
    localparam logic [31:0] RIFF_HDR = 32'd8;

    // skip counter values at which a fmt field has fully arrived
    localparam logic [31:0] FMT_AT_CHANNELS = 32'd13;
    localparam logic [31:0] FMT_AT_RATE     = 32'd9;
    localparam logic [31:0] FMT_AT_BITS     = 32'd1;

    typedef enum logic [2:0] {
        PH_RIFF,
        PH_RLEN,
        PH_WAVE,
        PH_TAG,
        PH_CLEN,
        PH_FMT,
        PH_SKIP,
        PH_IDLE
    } t_phase;

    typedef enum logic [2:0] {
        ST_DATA_FOUND = 3'd0,
        ST_BAD_RIFF   = 3'd1,
        ST_BAD_WAVE   = 3'd2,
        ST_NO_DATA    = 3'd3,
        ST_SHORT_FMT  = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       first_byte;
        logic       final_byte;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] channel_count;
        logic [31:0] rate_hz;
        logic [12:0] bytes_per_sample;
        logic [31:0] data_length;
    } t_out_word;

endpackage
`default_nettype wire

// ===== hw/rtl/whp_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// whp_core: parse state and per-byte step
// Holds the header walk state; one byte is consumed per enabled cycle.
// ----------------------------------------------------------------------------
module whp_core
    import whp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    input  wire t_in_word  i_word,
    output logic           o_res_valid,
    output t_out_word      o_res
);

    t_phase      r_phase, n_phase, c_phase;
    logic [31:0] r_pos, n_pos, c_pos;
    logic [31:0] r_end, n_end, c_end;
    logic [31:0] r_shift, n_shift, c_shift;
    logic [1:0]  r_cnt, n_cnt, c_cnt;
    logic [31:0] r_tag, n_tag, c_tag;
    logic [31:0] r_skip, n_skip, c_skip;
    logic [15:0] r_chan, n_chan, c_chan;
    logic [31:0] r_rate, n_rate, c_rate;
    logic [15:0] r_bits, n_bits, c_bits;

    logic [31:0] s_pos_inc;
    logic [31:0] s_shift_new;
    logic        s_end_reached;
    logic        s_word_done;
    logic        s_hit;
    t_status     s_status;
    logic [31:0] s_dlen;

    // a first byte restarts the parse before it is taken
    assign c_phase = i_word.first_byte ? PH_RIFF : r_phase;
    assign c_pos   = i_word.first_byte ? '0 : r_pos;
    assign c_end   = i_word.first_byte ? '0 : r_end;
    assign c_shift = i_word.first_byte ? '0 : r_shift;
    assign c_cnt   = i_word.first_byte ? '0 : r_cnt;
    assign c_tag   = i_word.first_byte ? '0 : r_tag;
    assign c_skip  = i_word.first_byte ? '0 : r_skip;
    assign c_chan  = i_word.first_byte ? '0 : r_chan;
    assign c_rate  = i_word.first_byte ? '0 : r_rate;
    assign c_bits  = i_word.first_byte ? '0 : r_bits;

    assign s_pos_inc     = c_pos + 32'd1;
    assign s_shift_new   = {i_word.file_byte, c_shift[31:8]};
    assign s_end_reached = (s_pos_inc >= c_end);
    assign s_word_done   = (c_cnt == 2'd3);

    // next state and status
    always_comb begin
        n_phase  = c_phase;
        n_pos    = c_pos;
        n_end    = c_end;
        n_shift  = c_shift;
        n_cnt    = c_cnt;
        n_tag    = c_tag;
        n_skip   = c_skip;
        n_chan   = c_chan;
        n_rate   = c_rate;
        n_bits   = c_bits;
        s_hit    = 1'b0;
        s_status = ST_NO_DATA;
        s_dlen   = '0;
        if (c_phase != PH_IDLE) begin
            n_pos   = s_pos_inc;
            n_shift = s_shift_new;
            if (c_phase inside {PH_RIFF, PH_RLEN, PH_WAVE, PH_TAG, PH_CLEN}) begin
                n_cnt = c_cnt + 2'd1;
            end
            case (c_phase)
                PH_RIFF: begin
                    if (s_word_done) begin
                        if (s_shift_new != TAG_RIFF) begin
                            s_hit    = 1'b1;
                            s_status = ST_BAD_RIFF;
                        end else begin
                            n_phase = PH_RLEN;
                        end
                    end
                end
                PH_RLEN: begin
                    if (s_word_done) begin
                        n_end   = s_shift_new + RIFF_HDR;
                        n_phase = PH_WAVE;
                    end
                end
                PH_WAVE: begin
                    if (s_word_done) begin
                        if (s_shift_new != TAG_WAVE) begin
                            s_hit    = 1'b1;
                            s_status = ST_BAD_WAVE;
                        end else if (s_end_reached) begin
                            s_hit = 1'b1;
                        end else begin
                            n_phase = PH_TAG;
                            n_cnt   = '0;
                        end
                    end
                end
                PH_TAG: begin
                    if (s_word_done) begin
                        n_tag   = s_shift_new;
                        n_phase = PH_CLEN;
                    end
                end
                PH_CLEN: begin
                    if (s_word_done) begin
                        if (c_tag == TAG_FMT) begin
                            if (s_shift_new < FMT_MIN) begin
                                s_hit    = 1'b1;
                                s_status = ST_SHORT_FMT;
                            end else begin
                                n_tag   = s_shift_new - FMT_MIN;
                                n_skip  = FMT_MIN;
                                n_phase = PH_FMT;
                            end
                        end else if (c_tag == TAG_DATA) begin
                            s_hit    = 1'b1;
                            s_status = ST_DATA_FOUND;
                            s_dlen   = s_shift_new;
                        end else begin
                            n_skip = s_shift_new;
                            if (s_shift_new != '0) begin
                                n_phase = PH_SKIP;
                            end else if (s_end_reached) begin
                                s_hit = 1'b1;
                            end else begin
                                n_phase = PH_TAG;
                                n_cnt   = '0;
                            end
                        end
                    end
                end
                PH_FMT: begin
                    n_skip = c_skip - 32'd1;
                    if (c_skip == FMT_AT_CHANNELS) begin
                        n_chan = s_shift_new[31:16];
                    end else if (c_skip == FMT_AT_RATE) begin
                        n_rate = s_shift_new;
                    end else if (c_skip == FMT_AT_BITS) begin
                        n_bits = s_shift_new[31:16];
                    end
                    if (c_skip == 32'd1) begin
                        // the tag register holds the extra byte count while in fmt
                        n_skip = c_tag;
                        if (c_tag != '0) begin
                            n_phase = PH_SKIP;
                        end else if (s_end_reached) begin
                            s_hit = 1'b1;
                        end else begin
                            n_phase = PH_TAG;
                            n_cnt   = '0;
                        end
                    end
                end
                PH_SKIP: begin
                    n_skip = c_skip - 32'd1;
                    if (c_skip == 32'd1) begin
                        if (s_end_reached) begin
                            s_hit = 1'b1;
                        end else begin
                            n_phase = PH_TAG;
                            n_cnt   = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (!s_hit && i_word.final_byte) begin
                s_hit    = 1'b1;
                s_status = ST_NO_DATA;
            end
            if (s_hit) begin
                n_phase = PH_IDLE;
            end
        end
    end

    // result word
    always_comb begin
        o_res_valid            = i_step && s_hit;
        o_res.status           = s_status;
        o_res.channel_count    = n_chan;
        o_res.rate_hz          = n_rate;
        o_res.bytes_per_sample = n_bits[15:3];
        o_res.data_length      = s_dlen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RIFF;
            r_pos   <= '0;
            r_end   <= '0;
            r_shift <= '0;
            r_cnt   <= '0;
            r_tag   <= '0;
            r_skip  <= '0;
            r_chan  <= '0;
            r_rate  <= '0;
            r_bits  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_end   <= n_end;
            r_shift <= n_shift;
            r_cnt   <= n_cnt;
            r_tag   <= n_tag;
            r_skip  <= n_skip;
            r_chan  <= n_chan;
            r_rate  <= n_rate;
            r_bits  <= n_bits;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/wave_header_parser_unit.sv =====
`default_nettype none
// Timing: a byte word accepted into the input register is processed once the parse step runs;
//   its result word, if any, is registered and presented on the output until taken.
// Throughput: one byte word per cycle while the output side does not stall.
// Reset: synchronous active-low i_rst_n empties both word registers and puts the
//   parser at the start of a file, as does a byte word with first_byte set.
// ----------------------------------------------------------------------------
// wave_header_parser_unit: RIFF/WAVE header parser, one byte per word
// Input register, parse step, output register with valid/ready on both sides.
// ----------------------------------------------------------------------------
module wave_header_parser_unit
    import whp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_word
);

    // input register: holds one byte word waiting for the parse step
    logic      r_in_valid;
    t_in_word  r_in_word;

    // output register: holds one result word until it is taken
    logic      r_out_valid;
    t_out_word r_out_word;

    logic      s_advance;
    logic      s_step;
    logic      s_res_valid;
    t_out_word s_res;

    // the step runs when its result, if any, has a free slot downstream;
    // a word taken at the output frees the slot in the same cycle
    assign s_advance  = !r_out_valid || i_out_ready;
    assign s_step     = r_in_valid && s_advance;
    assign o_in_ready = !r_in_valid || s_advance;

    whp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (s_step),
        .i_word      (r_in_word),
        .o_res_valid (s_res_valid),
        .o_res       (s_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_advance) begin
            r_out_valid <= s_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_advance && s_res_valid) begin
            r_out_word <= s_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // a result only comes out of a step that actually ran
    a_res_needs_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_res_valid |-> s_step)
        else $error("result without a parse step");

    // a stalled output word is never overwritten by a new step
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !s_step)
        else $error("parse step while output word is stalled");

    // after a result, the next step yields nothing unless a new file starts
    a_one_per_file: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_res_valid |=> !(s_res_valid && !r_in_word.first_byte))
        else $error("second result within one file");

    // data length is zero unless a data chunk was found
    a_dlen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.status == ST_DATA_FOUND
                         || o_out_word.data_length == 32'd0))
        else $error("data length set on a failure status");

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the wave header parser
// Streams whole RIFF/WAVE files into wave_header_parser_unit one byte word at
// a time: directed files for each parse outcome and corner case, then random
// files (mostly well formed, some broken, some loose words), with idle gaps on
// both channels and a long output stall. A byte-level parser model predicts
// every result word; each one taken from the block is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import whp_pkg::*;

    // tags as the shift register holds them after four bytes: first byte in
    // the low lane, so the strings read back to front
    localparam logic [31:0] ID_RIFF = "FFIR";
    localparam logic [31:0] ID_WAVE = "EVAW";
    localparam logic [31:0] ID_FMT  = " tmf";
    localparam logic [31:0] ID_DATA = "atad";

    localparam logic [31:0] FMT_BODY  = 32'd16;  // shortest legal fmt body
    localparam logic [31:0] HDR_BYTES = 32'd8;   // RIFF tag plus RIFF length
    localparam int MAX_BODY      = 24;           // most bytes actually sent for a chunk body
    localparam int PHASE_BYTES   = 40;           // fewest parsed words per random phase
    localparam int PHASE_RESULTS = 1;            // fewest results per random phase
    localparam int STALL_CYCLES  = 300;
    localparam int DRAIN_CYCLES  = 4;            // parse step plus output register, with slack
    localparam int TIMEOUT_TIME  = 5_000_000;

    // ------------------------------------------------------------------------
    // clock, reset, DUT ports (all inputs known from time zero)
    // ------------------------------------------------------------------------
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_word;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    wave_header_parser_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // ------------------------------------------------------------------------
    // parser model state
    // ------------------------------------------------------------------------
    t_phase      p_phase;
    logic [31:0] p_pos;      // bytes taken in this file
    logic [31:0] p_end;      // RIFF length + 8
    logic [31:0] p_shift;    // last four bytes, newest on top
    logic [2:0]  p_nbytes;   // bytes of the current 4-byte field
    logic [31:0] p_tag;      // chunk tag; fmt extra byte count while in a fmt body
    logic [31:0] p_left;     // bytes left in the current body
    logic [15:0] p_chan;
    logic [31:0] p_rate;
    logic [15:0] p_bits;
    logic        p_done;     // result given, wait for the next first byte

    t_out_word expected_headers[$];

    // bookkeeping
    int   tx_idle_pct = 11;
    int   rx_idle_pct = 55;
    int   parsed_bytes = 0;
    int   expected_total = 0;
    int   results_checked = 0;
    int   mismatches = 0;
    int   files_sent = 0;
    int   status_seen[8];
    logic stall_ask = 1'b0;
    logic stall_seen = 1'b0;
    int   stall_left = 0;

    logic [7:0] file_q[$];   // bytes of the file being built

    function automatic void clear_parser();
        p_phase  = PH_RIFF;
        p_pos    = '0;
        p_end    = '0;
        p_shift  = '0;
        p_nbytes = '0;
        p_tag    = '0;
        p_left   = '0;
        p_chan   = '0;
        p_rate   = '0;
        p_bits   = '0;
        p_done   = 1'b0;
    endfunction

    // One byte word through the parser model. Returns 1 when it yields a result.
    function automatic bit parse_header_byte(input t_in_word w, output t_out_word res);
        bit          have;
        bit          word_done;
        bit          open_chunk;
        t_status     st;
        logic [31:0] dlen;
        logic [31:0] idx;
        have       = 1'b0;
        word_done  = 1'b0;
        open_chunk = 1'b0;
        st         = ST_NO_DATA;
        dlen       = '0;
        res        = '0;
        if (w.first_byte)
            clear_parser();
        if (p_done)
            return 1'b0;
        parsed_bytes++;
        p_pos   = p_pos + 1;
        p_shift = {w.file_byte, p_shift[31:8]};
        if (p_phase <= PH_CLEN) begin
            p_nbytes = p_nbytes + 1;
            if (p_nbytes == 3'd4) begin
                p_nbytes  = '0;
                word_done = 1'b1;
            end
        end
        case (p_phase)
            PH_RIFF: if (word_done) begin
                if (p_shift != ID_RIFF) begin
                    have = 1'b1;
                    st   = ST_BAD_RIFF;
                end else
                    p_phase = PH_RLEN;
            end
            PH_RLEN: if (word_done) begin
                p_end   = p_shift + HDR_BYTES;
                p_phase = PH_WAVE;
            end
            PH_WAVE: if (word_done) begin
                if (p_shift != ID_WAVE) begin
                    have = 1'b1;
                    st   = ST_BAD_WAVE;
                end else
                    open_chunk = 1'b1;
            end
            PH_TAG: if (word_done) begin
                p_tag   = p_shift;
                p_phase = PH_CLEN;
            end
            PH_CLEN: if (word_done) begin
                if (p_tag == ID_FMT) begin
                    if (p_shift < FMT_BODY) begin
                        have = 1'b1;
                        st   = ST_SHORT_FMT;
                    end else begin
                        p_tag   = p_shift - FMT_BODY;
                        p_left  = FMT_BODY;
                        p_phase = PH_FMT;
                    end
                end else if (p_tag == ID_DATA) begin
                    have = 1'b1;
                    st   = ST_DATA_FOUND;
                    dlen = p_shift;
                end else begin
                    p_left = p_shift;
                    if (p_left == 0)
                        open_chunk = 1'b1;
                    else
                        p_phase = PH_SKIP;
                end
            end
            PH_FMT: begin
                // a field is kept only once its last byte is in
                idx    = FMT_BODY - p_left;
                p_left = p_left - 1;
                if (idx == 3)
                    p_chan = p_shift[31:16];
                else if (idx == 7)
                    p_rate = p_shift;
                else if (idx == 15)
                    p_bits = p_shift[31:16];
                if (p_left == 0) begin
                    p_left = p_tag;
                    if (p_left == 0)
                        open_chunk = 1'b1;
                    else
                        p_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                p_left = p_left - 1;
                if (p_left == 0)
                    open_chunk = 1'b1;
            end
            default: ;
        endcase
        // end position is checked only at chunk boundaries
        if (open_chunk) begin
            if (p_pos >= p_end) begin
                have = 1'b1;
                st   = ST_NO_DATA;
            end else begin
                p_phase  = PH_TAG;
                p_nbytes = '0;
            end
        end
        if (!have && w.final_byte) begin
            have = 1'b1;
            st   = ST_NO_DATA;
        end
        if (!have)
            return 1'b0;
        p_done               = 1'b1;
        p_phase              = PH_IDLE;
        res.status           = st;
        res.channel_count    = p_chan;
        res.rate_hz          = p_rate;
        res.bytes_per_sample = p_bits[15:3];
        res.data_length      = dlen;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // monitor: check each result word taken, predict from each byte word taken.
    // Sampled right at the edge, before any nonblocking update lands.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_word predicted;
        t_out_word want;
        if (!i_rst_n)
            clear_parser();
        else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_headers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result word status=%0d len=%h",
                                 o_out_word.status, o_out_word.data_length);
                end else begin
                    want = expected_headers.pop_front();
                    results_checked++;
                    status_seen[want.status]++;
                    if (o_out_word.status           !== want.status ||
                        o_out_word.channel_count    !== want.channel_count ||
                        o_out_word.rate_hz          !== want.rate_hz ||
                        o_out_word.bytes_per_sample !== want.bytes_per_sample ||
                        o_out_word.data_length      !== want.data_length) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("ERROR: result %0d mismatch", results_checked);
                            $display("  got  st=%0d ch=%h rate=%h bps=%h len=%h",
                                     o_out_word.status, o_out_word.channel_count,
                                     o_out_word.rate_hz,
                                     o_out_word.bytes_per_sample, o_out_word.data_length);
                            $display("  want st=%0d ch=%h rate=%h bps=%h len=%h",
                                     want.status, want.channel_count, want.rate_hz,
                                     want.bytes_per_sample, want.data_length);
                        end
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                if (parse_header_byte(i_in_word, predicted)) begin
                    expected_headers.push_back(predicted);
                    expected_total++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result side: random ready, or a long hold-off when a test asks for one
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_seen != stall_ask) begin
            stall_seen  <= stall_ask;
            stall_left  <= STALL_CYCLES;
            i_out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else
            i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // ------------------------------------------------------------------------
    // byte side
    // ------------------------------------------------------------------------
    task automatic send_byte(input t_in_word w);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    // first word of the file restarts the parser; last may carry final_byte
    task automatic send_file(input bit mark_final);
        t_in_word w;
        files_sent++;
        foreach (file_q[k]) begin
            w.file_byte  = file_q[k];
            w.first_byte = (k == 0);
            w.final_byte = mark_final && (k == file_q.size() - 1);
            send_byte(w);
        end
    endtask

    // stop sending until every predicted result word has been taken
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_headers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // file building, little-endian fields
    // ------------------------------------------------------------------------
    task automatic push_word(input logic [31:0] v);
        for (int k = 0; k < 4; k++)
            file_q.push_back(v[8*k +: 8]);
    endtask

    task automatic set_riff_len(input logic [31:0] v);
        for (int k = 0; k < 4; k++)
            file_q[4 + k] = v[8*k +: 8];
    endtask

    task automatic cut_file(input int keep);
        while (file_q.size() > keep)
            void'(file_q.pop_back());
    endtask

    task automatic start_wave();
        file_q.delete();
        push_word(ID_RIFF);
        push_word('0);
        push_word(ID_WAVE);
    endtask

    task automatic push_fmt(input logic [31:0] len, input logic [15:0] ch,
                            input logic [31:0] rate, input logic [15:0] bits);
        push_word(ID_FMT);
        push_word(len);
        push_word({ch, 16'($urandom)});     // format code, channels
        push_word(rate);
        push_word($urandom);                // byte rate, unused
        push_word({bits, 16'($urandom)});   // block align, bits per sample
        if (len > FMT_BODY && len <= FMT_BODY + MAX_BODY)
            repeat (len - FMT_BODY) file_q.push_back(8'($urandom));
    endtask

    // chunk of some other kind; only the first MAX_BODY body bytes are sent
    task automatic push_unknown(input logic [31:0] len);
        logic [31:0] tag;
        do
            tag = $urandom;
        while (tag == ID_FMT || tag == ID_DATA);
        push_word(tag);
        push_word(len);
        repeat ((len > MAX_BODY) ? MAX_BODY : len) file_q.push_back(8'($urandom));
    endtask

    // data chunk header, a few sample bytes, RIFF length covering it all
    task automatic end_wave(input logic [31:0] dlen);
        push_word(ID_DATA);
        push_word(dlen);
        repeat ($urandom_range(0, 3)) file_q.push_back(8'($urandom));
        set_riff_len(file_q.size() - HDR_BYTES);
    endtask

    // ------------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------------
    task automatic test_wellformed();
        start_wave();
        push_fmt(FMT_BODY, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        end_wave(32'hFFFF_FFFF);
        send_file(1'b1);
        // zero fields; 7 bits per sample truncates to 0 bytes
        start_wave();
        push_fmt(FMT_BODY, '0, '0, 16'd7);
        end_wave('0);
        send_file(1'b1);
        // data without any fmt chunk
        start_wave();
        end_wave($urandom);
        send_file(1'b1);
        // empty chunk, fmt with extra bytes, skipped chunk, second fmt wins
        start_wave();
        push_unknown('0);
        push_fmt(FMT_BODY + 1, 16'd1, 32'd8000, 16'd8);
        push_unknown(32'd3);
        push_fmt(FMT_BODY + 4, 16'd2, 32'd48000, 16'd24);
        end_wave($urandom);
        send_file(1'b1);
    endtask

    task automatic test_bad_tags();
        start_wave();
        file_q[3] = "X";
        send_file(1'b1);
        start_wave();
        file_q[8] = 8'h00;
        send_file(1'b1);
    endtask

    // the file stops at the fmt length field, where the verdict falls
    task automatic test_short_fmt();
        start_wave();
        push_fmt(FMT_BODY - 1, 16'd2, 32'd44100, 16'd16);
        end_wave($urandom);
        cut_file(20);
        send_file(1'b1);
        start_wave();
        push_fmt('0, 16'd2, 32'd44100, 16'd16);
        end_wave($urandom);
        cut_file(20);
        send_file(1'b1);
    endtask

    task automatic test_end_position();
        // end falls right after the WAVE tag
        start_wave();
        end_wave($urandom);
        set_riff_len(32'd4);
        cut_file(12);
        send_file(1'b1);
        // RIFF length + 8 wraps to 0, then to 7
        set_riff_len(32'hFFFF_FFF8);
        send_file(1'b1);
        set_riff_len(32'hFFFF_FFFF);
        send_file(1'b1);
        // end right after the fmt body: kept values go out with the failure
        start_wave();
        push_fmt(FMT_BODY, 16'd4, 32'd96000, 16'd32);
        end_wave($urandom);
        set_riff_len(32'd28);
        send_file(1'b1);
    endtask

    task automatic test_truncated();
        // one byte only, flagged as the last
        start_wave();
        cut_file(1);
        send_file(1'b1);
        // stops inside the rate field, then inside the bits field
        start_wave();
        push_fmt(FMT_BODY, 16'd2, 32'd44100, 16'd16);
        end_wave($urandom);
        cut_file(26);
        send_file(1'b1);
        start_wave();
        push_fmt(FMT_BODY, 16'd2, 32'd44100, 16'd16);
        end_wave($urandom);
        cut_file(35);
        send_file(1'b1);
    endtask

    task automatic test_skips();
        // skip of 20 runs past an end at 20, end check after it
        start_wave();
        push_unknown(32'd20);
        end_wave($urandom);
        set_riff_len(32'd12);
        send_file(1'b1);
        // largest chunk length, file ends mid-skip
        start_wave();
        push_unknown(32'hFFFF_FFFF);
        set_riff_len(32'hFFFF_FFF0);
        send_file(1'b1);
        // largest fmt length, ends among the extra bytes
        start_wave();
        push_fmt(32'hFFFF_FFFF, 16'd6, 32'd96000, 16'd32);
        repeat (3) file_q.push_back(8'($urandom));
        set_riff_len(32'hFFFF_FFF0);
        send_file(1'b1);
    endtask

    task automatic test_restart();
        // file abandoned mid-fmt without a last flag, next first byte restarts
        start_wave();
        push_fmt(FMT_BODY, 16'd3, 32'd22050, 16'd8);
        end_wave($urandom);
        cut_file(30);
        send_file(1'b0);
        start_wave();
        push_fmt(FMT_BODY, 16'd1, 32'd11025, 16'd16);
        end_wave($urandom);
        send_file(1'b1);
    endtask

    // ------------------------------------------------------------------------
    // random files: mostly well formed with random content
    // ------------------------------------------------------------------------
    task automatic send_random_file();
        int          kind;
        t_in_word    w;
        logic [31:0] len_fmt;
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            // loose words: flags anywhere, may restart or end a file midway
            repeat ($urandom_range(2, 8)) begin
                w.file_byte  = 8'($urandom);
                w.first_byte = 1'($urandom);
                w.final_byte = 1'($urandom);
                send_byte(w);
            end
        end else begin
            len_fmt = ($urandom_range(0, 3) == 0) ? FMT_BODY + $urandom_range(1, 6) : FMT_BODY;
            if (kind == 1)
                len_fmt = $urandom_range(0, FMT_BODY - 1);
            start_wave();
            repeat ($urandom_range(0, 2)) push_unknown($urandom_range(0, 6));
            if ($urandom_range(0, 7) != 0)
                push_fmt(len_fmt,
                         ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 8)),
                         $urandom,
                         ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                     : 16'(8 * $urandom_range(1, 4)));
            if ($urandom_range(0, 5) == 0)
                push_unknown($urandom_range(0, 12));
            end_wave($urandom);
            case (kind)
                2:       file_q[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
                3:       file_q[$urandom_range(8, 11)] ^= 8'($urandom_range(1, 255));
                4:       set_riff_len($urandom_range(0, file_q.size() - 9));
                5, 6:    cut_file($urandom_range(1, file_q.size() - 1));
                default: ;
            endcase
            // 6 and 7 leave the file open; the next first byte restarts it
            send_file(kind != 6 && kind != 7);
        end
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct);
        int bytes_at_start;
        int results_at_start;
        tx_idle_pct      = tx_pct;
        rx_idle_pct      = rx_pct;
        bytes_at_start   = parsed_bytes;
        results_at_start = expected_total;
        while (parsed_bytes - bytes_at_start < PHASE_BYTES ||
               expected_total - results_at_start < PHASE_RESULTS)
            send_random_file();
        wait_drained();
    endtask

    // receiver holds off while short bad-tag files keep producing results,
    // so both word registers fill and the byte side stalls
    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        stall_ask <= ~stall_ask;
        repeat (12) begin
            start_wave();
            file_q[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
            cut_file(4);
            send_file(1'b0);
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        int failures;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_wellformed();
        test_bad_tags();
        test_short_fmt();
        test_end_position();
        test_truncated();
        test_skips();
        test_restart();
        wait_drained();

        test_random_traffic(11, 55);
        test_random_traffic(55, 11);
        test_random_traffic(0, 0);
        test_output_stall();

        failures = mismatches + expected_headers.size();
        if (expected_headers.size() != 0)
            $display("ERROR: %0d predicted results never came out", expected_headers.size());
        $display("Sent %0d files, %0d bytes parsed, %0d header results checked",
                 files_sent, parsed_bytes, results_checked);
        $display("By status: data %0d, bad RIFF %0d, bad WAVE %0d, no data %0d, short fmt %0d",
                 status_seen[ST_DATA_FOUND], status_seen[ST_BAD_RIFF],
                 status_seen[ST_BAD_WAVE], status_seen[ST_NO_DATA],
                 status_seen[ST_SHORT_FMT]);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #(TIMEOUT_TIME);
        $display("ERROR: timeout, parser stopped moving words");
        $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

// ===== wave_header_parser_unit.f =====
hw/rtl/whp_pkg.sv
hw/rtl/whp_core.sv
hw/rtl/wave_header_parser_unit.sv
test/tb_top.sv
